### rtl/lks_pkg.sv
// package for the knn top-k select unit: result and request structs and constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lks_pkg;
    localparam int unsigned DistBits = 32;
    localparam int unsigned IdxBits  = 32;
    localparam int unsigned RankBits = 6;
    localparam int unsigned KRegBits = 7;
    localparam int unsigned DRegBits = 8;
    localparam logic [0:0]  CfgK     = 1'b0;
    localparam logic [0:0]  CfgDim   = 1'b1;
    localparam logic        ReqQuery = 1'b0;

    typedef struct packed {
        logic [31:0] neighbour_index;
        logic [31:0] neighbour_distance;
        logic [5:0]  rank;
        logic        last;
    } t_result;

    typedef struct packed {
        logic       req_type;
        logic [7:0] component;
        logic       last_of_set;
    } t_request;
endpackage
`default_nettype wire

### rtl/lks_if.sv
// valid/ready channel carrying a payload of type T
// depends on lks_pkg for the payload types used at instantiation
`timescale 1ns / 1ps
`default_nettype none
interface lks_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/lks_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module lks_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 128
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(Depth)-1:0]  i_waddr,
    input  wire [Width-1:0]          i_wdata,
    input  wire [$clog2(Depth)-1:0]  i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/l2_knn_topk_select_unit.sv
// top level of the knn top-k select unit
// depends on lks_pkg, lks_if and lks_ram
`timescale 1ns / 1ps
`default_nettype none
// exact k-nearest-neighbour search by squared l2 distance. query components are
// loaded into a query ram (req_type 0), then candidates stream one component per
// request. each candidate request first reads the query ram (registered read),
// then accumulates. when a candidate completes it is inserted into the sorted
// list held in the top-k ram, shifting held entries down one at a time, since
// the list is walked from the worst end one entry at a time through the ram's
// single read port. on last_of_set the held neighbours are read out in rank
// order, each result read from the ram, then loaded into the output register;
// the output register lets the next read proceed while a result waits.
module l2_knn_topk_select_unit #(
    parameter int unsigned MAX_K   = 64,
    parameter int unsigned MAX_DIM = 128
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_cfg_we,
    input  wire  [0:0] i_cfg_index,
    input  wire  [lks_pkg::DRegBits-1:0] i_cfg_data,
    lks_if.sink   s_req,
    lks_if.source m_res
);
    import lks_pkg::*;

    localparam int unsigned KW = $clog2(MAX_K + 1);
    localparam int unsigned AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int unsigned DW = $clog2(MAX_DIM + 1);
    localparam int unsigned QW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int unsigned EW = DistBits + IdxBits;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACC  = 6'b000010,
        S_INS  = 6'b000100,
        S_INSR = 6'b001000,
        S_EMIT = 6'b010000,
        S_EMRD = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [KRegBits-1:0] r_k;
    logic [DRegBits-1:0] r_dim;
    logic [DistBits-1:0] r_acc, n_acc;
    logic [DW-1:0]       r_cnt, n_cnt;
    logic [IdxBits-1:0]  r_cand, n_cand;
    logic [KW-1:0]       r_held, n_held;
    logic [KW-1:0]       r_pos, n_pos;
    logic                r_lastset, n_lastset;
    logic [7:0]          r_comp, n_comp;
    logic [DistBits-1:0] r_ndist, n_ndist;
    logic [IdxBits-1:0]  r_nidx, n_nidx;
    logic                r_ovalid, n_ovalid;
    t_result             r_out, n_out;
    logic [KW-1:0]       r_n, n_n;

    // effective register values
    logic [KW-1:0] w_k;
    logic [DW-1:0] w_dim;
    always_comb begin
        if (r_k == '0) begin
            w_k = KW'(1);
        end else if (32'(r_k) > MAX_K) begin
            w_k = KW'(MAX_K);
        end else begin
            w_k = KW'(r_k);
        end
        if (r_dim == '0) begin
            w_dim = DW'(1);
        end else if (32'(r_dim) > MAX_DIM) begin
            w_dim = DW'(MAX_DIM);
        end else begin
            w_dim = DW'(r_dim);
        end
    end

    // query ram
    logic          q_we;
    logic [QW-1:0] q_addr;
    logic [7:0]    q_rdata;
    logic [DW-1:0] w_pos;
    assign w_pos  = (r_cnt >= w_dim) ? '0 : r_cnt;
    assign q_addr = w_pos[QW-1:0];
    lks_ram #(.Width(8), .Depth(MAX_DIM)) u_qram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_addr),
        .i_wdata(s_req.payload.component), .i_raddr(q_addr), .o_rdata(q_rdata)
    );

    // top-k list ram, entry = {distance, index}
    logic          b_we;
    logic [AW-1:0] b_waddr, b_raddr;
    logic [EW-1:0] b_wdata, b_rdata;
    lks_ram #(.Width(EW), .Depth(MAX_K)) u_bram (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr),
        .i_wdata(b_wdata), .i_raddr(b_raddr), .o_rdata(b_rdata)
    );
    logic [DistBits-1:0] w_bd;
    logic [IdxBits-1:0]  w_bi;
    assign w_bd = b_rdata[EW-1:IdxBits];
    assign w_bi = b_rdata[IdxBits-1:0];

    // accumulate step
    logic signed [17:0] w_diff;
    logic        [17:0] w_sq;
    logic        [DistBits:0] w_sum;
    logic [DistBits-1:0] w_accsat;
    assign w_diff   = $signed({2'b00, r_comp}) - $signed({2'b00, q_rdata});
    assign w_sq     = $unsigned(w_diff * w_diff);
    assign w_sum    = {1'b0, r_acc} + (DistBits+1)'(w_sq);
    assign w_accsat = w_sum[DistBits] ? '1 : w_sum[DistBits-1:0];

    logic [KW-1:0] w_heldc;
    assign w_heldc = (r_held > w_k) ? w_k : r_held;

    assign s_req.ready   = (r_state == S_IDLE) && !r_ovalid;
    assign m_res.valid   = r_ovalid;
    assign m_res.payload = r_out;

    always_comb begin
        n_state = r_state; n_acc = r_acc; n_cnt = r_cnt; n_cand = r_cand;
        n_held = r_held; n_pos = r_pos; n_lastset = r_lastset; n_comp = r_comp;
        n_ndist = r_ndist; n_nidx = r_nidx; n_ovalid = r_ovalid; n_out = r_out;
        n_n = r_n;
        q_we = 1'b0; b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_raddr = '0;
        if (m_res.valid && m_res.ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (s_req.valid && s_req.ready) begin
                    if (s_req.payload.req_type == ReqQuery) begin
                        q_we = 1'b1;
                        n_cnt = (w_pos + DW'(1) >= w_dim) ? '0 : w_pos + DW'(1);
                    end else begin
                        n_comp = s_req.payload.component;
                        n_lastset = s_req.payload.last_of_set;
                        n_cnt = w_pos;
                        n_state = S_ACC;
                    end
                end
            end
            S_ACC: begin
                n_acc = w_accsat;
                n_cnt = r_cnt + DW'(1);
                n_state = S_IDLE;
                if (r_cnt + DW'(1) >= w_dim || r_lastset) begin
                    n_ndist = w_accsat;
                    n_nidx = r_cand;
                    n_cand = r_cand + IdxBits'(1);
                    n_acc = '0;
                    n_cnt = '0;
                    if (w_heldc >= w_k) begin
                        // compare against worst entry first
                        n_held = w_k - KW'(1);
                        n_pos = w_k;
                        b_raddr = AW'(w_k - KW'(1));
                        n_state = S_INSR;
                    end else begin
                        n_held = w_heldc;
                        n_pos = w_heldc;
                        b_raddr = AW'(w_heldc - KW'(1));
                        n_state = S_INS;
                    end
                end else if (r_lastset) begin
                    n_state = S_EMIT;
                end
            end
            S_INSR: begin
                // full list: replace only on strictly smaller distance
                if (r_ndist < w_bd) begin
                    n_pos = r_held;
                    b_raddr = AW'(r_held - KW'(1));
                    n_state = S_INS;
                end else begin
                    n_held = r_held + KW'(1);
                    n_state = r_lastset ? S_EMIT : S_IDLE;
                    n_pos = '0;
                end
            end
            S_INS: begin
                // b_rdata holds entry pos-1
                if (r_pos != '0 && ((w_bd > r_ndist) ||
                        (w_bd == r_ndist && w_bi > r_nidx))) begin
                    b_we = 1'b1;
                    b_waddr = AW'(r_pos);
                    b_wdata = b_rdata;
                    n_pos = r_pos - KW'(1);
                    b_raddr = AW'(r_pos - KW'(2));
                end else begin
                    b_we = 1'b1;
                    b_waddr = AW'(r_pos);
                    b_wdata = {r_ndist, r_nidx};
                    n_held = r_held + KW'(1);
                    n_pos = '0;
                    n_state = r_lastset ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                // start readout of rank r_pos
                if (r_pos == '0) begin
                    n_n = w_heldc;
                end
                if ((r_pos == '0 && w_heldc == '0) || (r_pos != '0 && r_pos >= r_n)) begin
                    n_acc = '0; n_cnt = '0; n_cand = '0; n_held = '0; n_pos = '0;
                    n_state = S_IDLE;
                end else begin
                    b_raddr = AW'(r_pos);
                    n_state = S_EMRD;
                end
            end
            S_EMRD: begin
                if (!r_ovalid || m_res.ready) begin
                    n_ovalid = 1'b1;
                    n_out.neighbour_index = w_bi;
                    n_out.neighbour_distance = w_bd;
                    n_out.rank = RankBits'(r_pos);
                    n_out.last = (r_pos + KW'(1) == r_n);
                    n_pos = r_pos + KW'(1);
                    n_state = S_EMIT;
                end else begin
                    b_raddr = AW'(r_pos);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k <= KRegBits'(10);
            r_dim <= DRegBits'(128);
            r_acc <= '0; r_cnt <= '0; r_cand <= '0; r_held <= '0; r_pos <= '0;
            r_ovalid <= 1'b0; r_lastset <= 1'b0; r_n <= '0;
        end else begin
            r_state <= n_state;
            r_acc <= n_acc; r_cnt <= n_cnt; r_cand <= n_cand; r_held <= n_held;
            r_pos <= n_pos; r_ovalid <= n_ovalid; r_lastset <= n_lastset; r_n <= n_n;
            if (i_cfg_we) begin
                if (i_cfg_index == CfgK) begin
                    r_k <= i_cfg_data[KRegBits-1:0];
                end else if (i_cfg_index == CfgDim) begin
                    r_dim <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_comp <= n_comp; r_ndist <= n_ndist; r_nidx <= n_nidx; r_out <= n_out;
    end
endmodule
`default_nettype wire
